// File: rtl/i2da_pkg.sv
// Shared constants and types for the integer-to-decimal text converter.
// Used by i2da_cell and int_to_decimal_ascii_core; depends on nothing.
package i2da_pkg;

  localparam int ValueWidth = 32;
  localparam int NumCells   = 10;   // decimal digits of the largest magnitude
  localparam int DigitWidth = 4;
  localparam int CharWidth  = 6;
  localparam int BitCntW    = $clog2(ValueWidth);
  localparam int RemainW    = $clog2(NumCells + 1);

  localparam logic [CharWidth-1:0] CharZero  = CharWidth'(48);
  localparam logic [CharWidth-1:0] CharMinus = CharWidth'(45);

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_CLEAR = 2'd1,
    CELL_CONV  = 2'd2,
    CELL_SHIFT = 2'd3
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
  } cell_ctrl_t;

endpackage

// File: rtl/int_to_decimal_ascii_core.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Depends on i2da_pkg and i2da_cell.
//
// Usage:
//   Input channel: value_i with in_valid_i / in_stall_o. A word is taken when
//   in_valid_i is high and in_stall_o is low. One number is in flight at a
//   time; in_stall_o stays high from the accept until the final character
//   has been placed in the output register.
//   Output channel: character_o and last_o with out_valid_o / out_stall_i.
//   Characters leave most significant first, a '-' ahead of negative values,
//   leading zeros dropped, last_o high on the final character.
//   Timing: a row of ten digit cells takes the magnitude one bit per cycle,
//   then shifts the digits out toward the top cell one per cycle unless a
//   held output word stalls them, the sign going out first when negative.
//   Stalls: while out_stall_i is high and the output register holds a word,
//   it keeps that word and the emit sequence waits; skipped leading zeros
//   still advance.
//   Reset: the controller returns to idle and the output register empties.
module int_to_decimal_ascii_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [i2da_pkg::ValueWidth-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [i2da_pkg::CharWidth-1:0]      character_o,
  output logic                                last_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [i2da_pkg::ValueWidth-1:0] mag_q, mag_d;
  logic                            neg_q, neg_d;
  logic                            started_q, started_d;
  logic [i2da_pkg::BitCntW-1:0]    bitcnt_q, bitcnt_d;
  logic [i2da_pkg::RemainW-1:0]    remain_q, remain_d;

  logic                            out_valid_q, out_valid_d;
  logic [i2da_pkg::CharWidth-1:0]  char_q, char_d;
  logic                            last_q, last_d;

  i2da_pkg::cell_ctrl_t            cell_ctrl;
  logic                            carry_w [i2da_pkg::NumCells+1];
  logic [i2da_pkg::DigitWidth-1:0] digit_w [i2da_pkg::NumCells];
  logic [i2da_pkg::DigitWidth-1:0] lower_w [i2da_pkg::NumCells];
  logic [i2da_pkg::DigitWidth-1:0] top_digit;

  logic can_load;
  logic show;
  logic final_slot;

  // Feed the magnitude into the bottom cell, most significant bit first.
  assign carry_w[0] = mag_q[i2da_pkg::ValueWidth-1];

  for (genvar i = 0; i < i2da_pkg::NumCells; i++) begin : g_cell
    if (i == 0) begin : g_bottom
      assign lower_w[i] = '0;
    end else begin : g_upper
      assign lower_w[i] = digit_w[i-1];
    end

    i2da_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .carry_i (carry_w[i]),
      .digit_i (lower_w[i]),
      .carry_o (carry_w[i+1]),
      .digit_o (digit_w[i])
    );
  end

  assign top_digit  = digit_w[i2da_pkg::NumCells-1];
  assign can_load   = !out_valid_q || !out_stall_i;
  assign final_slot = (remain_q == i2da_pkg::RemainW'(1));
  assign show       = started_q || (top_digit != '0) || final_slot;

  always_comb begin
    state_d        = state_q;
    mag_d          = mag_q;
    neg_d          = neg_q;
    started_d      = started_q;
    bitcnt_d       = bitcnt_q;
    remain_d       = remain_q;
    out_valid_d    = out_valid_q && out_stall_i;
    char_d         = char_q;
    last_d         = last_q;
    cell_ctrl.mode = i2da_pkg::CELL_HOLD;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          // Take the magnitude in unsigned form; the most negative value maps
          // to 2^31 on its own.
          mag_d          = value_i[i2da_pkg::ValueWidth-1] ?
                           i2da_pkg::ValueWidth'(-value_i) :
                           i2da_pkg::ValueWidth'(value_i);
          neg_d          = value_i[i2da_pkg::ValueWidth-1];
          started_d      = 1'b0;
          bitcnt_d       = '0;
          cell_ctrl.mode = i2da_pkg::CELL_CLEAR;
          state_d        = ST_CONV;
        end
      end
      ST_CONV: begin
        cell_ctrl.mode = i2da_pkg::CELL_CONV;
        mag_d          = {mag_q[i2da_pkg::ValueWidth-2:0], 1'b0};
        bitcnt_d       = bitcnt_q + i2da_pkg::BitCntW'(1);
        if (bitcnt_q == i2da_pkg::BitCntW'(i2da_pkg::ValueWidth - 1)) begin
          remain_d = i2da_pkg::RemainW'(i2da_pkg::NumCells);
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (neg_q) begin
          // Sign goes out ahead of the digits.
          if (can_load) begin
            out_valid_d = 1'b1;
            char_d      = i2da_pkg::CharMinus;
            last_d      = 1'b0;
            neg_d       = 1'b0;
          end
        end else if (!show || can_load) begin
          cell_ctrl.mode = i2da_pkg::CELL_SHIFT;
          remain_d       = remain_q - i2da_pkg::RemainW'(1);
          if (show) begin
            out_valid_d = 1'b1;
            char_d      = i2da_pkg::CharZero +
                          i2da_pkg::CharWidth'(top_digit);
            last_d      = final_slot;
            started_d   = 1'b1;
          end
          if (final_slot) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      neg_q       <= 1'b0;
      started_q   <= 1'b0;
      bitcnt_q    <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      started_q   <= started_d;
      bitcnt_q    <= bitcnt_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  // The ten cells always suffice: nothing may spill out of the top digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> !carry_w[i2da_pkg::NumCells])
    else $error("digit chain overflow out of top cell");

  // Emitting with no digit slots left would lose the final character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (remain_q != '0))
    else $error("emit phase with no digits remaining");

  // The sign must precede every digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && neg_q) |-> !started_q)
    else $error("sign pending after digits started");

  // Only a minus sign or a decimal digit ever leaves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o == i2da_pkg::CharMinus ||
                     (character_o >= i2da_pkg::CharZero &&
                      character_o <= i2da_pkg::CharZero + i2da_pkg::CharWidth'(9))))
    else $error("output character out of range");

  // A new number is only accepted after the previous one closed with last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && state_d == ST_IDLE) |=> (out_valid_o && last_o))
    else $error("number ended without a last character");

endmodule

// File: rtl/i2da_cell.sv
// One decimal digit of the shift-and-add-3 chain.
// Depends on i2da_pkg for the digit width and the control struct.
module i2da_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  i2da_pkg::cell_ctrl_t             ctrl_i,
  input  logic                             carry_i,
  input  logic [i2da_pkg::DigitWidth-1:0]  digit_i,
  output logic                             carry_o,
  output logic [i2da_pkg::DigitWidth-1:0]  digit_o
);

  logic [i2da_pkg::DigitWidth-1:0] digit_q, digit_d;
  logic [i2da_pkg::DigitWidth-1:0] adj;

  // Add 3 when the digit would overflow past 9 after the doubling.
  assign adj     = (digit_q >= i2da_pkg::DigitWidth'(5)) ?
                   digit_q + i2da_pkg::DigitWidth'(3) : digit_q;
  assign carry_o = adj[i2da_pkg::DigitWidth-1];
  assign digit_o = digit_q;

  always_comb begin
    case (ctrl_i.mode)
      i2da_pkg::CELL_CLEAR: digit_d = '0;
      i2da_pkg::CELL_CONV:  digit_d = {adj[i2da_pkg::DigitWidth-2:0], carry_i};
      i2da_pkg::CELL_SHIFT: digit_d = digit_i;
      default:              digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for int_to_decimal_ascii_core: directed table, then random words.
// Predicts each number's decimal text and checks every character leaving the block.
// Depends on i2da_pkg and the RTL of int_to_decimal_ascii_core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumDirected    = 20;
  localparam int NumRandom      = 290;
  localparam int HoldoffCycles  = 300;
  localparam int DrainCycles    = 64;
  localparam int MaxReported    = 10;

  typedef struct packed {
    logic [i2da_pkg::CharWidth-1:0] code;
    logic                           last;
  } text_char_t;

  logic                                   clk_i;
  logic                                   rst_ni;
  logic                                   in_valid_i;
  logic                                   in_stall_o;
  logic signed [i2da_pkg::ValueWidth-1:0] value_i;
  logic                                   out_valid_o;
  logic                                   out_stall_i;
  logic [i2da_pkg::CharWidth-1:0]         character_o;
  logic                                   last_o;

  // Characters still owed by the block, oldest first.
  text_char_t pending_chars[$];
  int         fail_count = 0;
  bit         quiet_phase = 1'b0;   // no gaps and no stalls while set
  bit         holdoff_req = 1'b0;   // ask the receiver for one long stall

  // Directed rows; an empty text means the expectation comes from the predictor.
  logic [i2da_pkg::ValueWidth-1:0] dir_value [NumDirected] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    32'd12345, -32'sd987654, 32'd1000000000, 32'd999999999, -32'sd1000000000,
    32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
    32'd42, -32'sd9
  };
  string dir_text [NumDirected] = '{
    "0", "1", "-1", "9", "", "", "", "",
    "", "", "1000000000", "", "-1000000000",
    "2147483647", "-2147483647", "-2147483648", "", "",
    "", "-9"
  };

  int_to_decimal_ascii_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxReported) $display("[%0t] %s", $realtime, msg);
  endfunction

  // Work out the decimal text of one word and queue its characters.
  function automatic void predict_decimal_text(input logic [i2da_pkg::ValueWidth-1:0] word);
    logic [i2da_pkg::ValueWidth-1:0] mag;
    logic [3:0]                      digits[i2da_pkg::NumCells];
    int                              nd;
    // 0x80000000 stays 2147483648
    mag = word[i2da_pkg::ValueWidth-1] ? (~word + 1'b1) : word;
    nd = 0;
    do begin
      digits[nd] = 4'(mag % 10);
      mag = mag / 10;
      nd++;
    end while (mag != 0 && nd < i2da_pkg::NumCells);
    if (word[i2da_pkg::ValueWidth-1])
      pending_chars.push_back(text_char_t'{code: i2da_pkg::CharMinus, last: 1'b0});
    for (int i = nd - 1; i >= 0; i--)
      pending_chars.push_back(text_char_t'{
        code: i2da_pkg::CharZero + i2da_pkg::CharWidth'(digits[i]), last: (i == 0)});
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Mix of full-range words, short numbers, values around powers of ten and edge values.
  function automatic logic [i2da_pkg::ValueWidth-1:0] pick_value();
    int                              r;
    int                              k;
    logic [i2da_pkg::ValueWidth-1:0] p;
    logic [i2da_pkg::ValueWidth-1:0] mag;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom();
    if (r >= 92) begin
      case ($urandom_range(0, 4))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h8000_0001;
        3:       return 32'hFFFF_FFFF;
        default: return 32'd0;
      endcase
    end
    k = (r < 75) ? $urandom_range(1, 9) : $urandom_range(0, 9);
    p = 1;
    repeat (k) p = p * 10;
    if (r < 75) mag = $urandom_range(0, p - 1);
    else        mag = p + $urandom_range(0, 2) - 1;
    return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
  endfunction

  // Offer one word after a random gap and hold it until it is taken.
  task automatic send_word(input logic [i2da_pkg::ValueWidth-1:0] word, input string text);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (text.len() == 0) begin
      predict_decimal_text(word);
    end else begin
      for (int i = 0; i < text.len(); i++)
        pending_chars.push_back(text_char_t'{
          code: i2da_pkg::CharWidth'(text[i]), last: (i == text.len() - 1)});
    end
  endtask

  // Drop valid and hold off until every owed character has left.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Reset, then the directed table, then random words with pressure phases.
  initial begin
    in_valid_i <= 1'b0;
    value_i    <= '0;
    rst_ni     <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) send_word(dir_value[i], dir_text[i]);
    wait_drained();

    for (int i = 0; i < NumRandom; i++) begin
      // Long receiver stall while words keep coming, so the input backs up.
      if (i == 30) holdoff_req = 1'b1;
      // Pause the sender until the block has emptied.
      if (i == 120 || i == 250) wait_drained();
      quiet_phase = (i >= 180 && i < 220);
      send_word(pick_value(), "");
    end
    quiet_phase = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_chars.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver stall pattern: runs of free and stalled cycles, plus one long hold-off.
  initial begin
    int run_left;
    int holdoff_left;
    int r;
    run_left     = 0;
    holdoff_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_req) begin
        holdoff_req  = 1'b0;
        holdoff_left = HoldoffCycles;
      end
      if (holdoff_left > 0) begin
        out_stall_i <= 1'b1;
        holdoff_left--;
        run_left = 0;
      end else if (quiet_phase) begin
        out_stall_i <= 1'b0;
        run_left = 0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        out_stall_i <= (r >= 45);
        if (r < 45)      run_left = $urandom_range(0, 5);
        else if (r < 85) run_left = $urandom_range(0, 2);
        else if (r < 97) run_left = $urandom_range(3, 11);
        else             run_left = $urandom_range(19, 59);
      end
    end
  end

  // Check every character taken from the block against the oldest expectation.
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        note_failure($sformatf("unexpected character %0d last %0b", character_o, last_o));
      end else begin
        want = pending_chars.pop_front();
        if (character_o !== want.code || last_o !== want.last)
          note_failure($sformatf("character exp %0d last %0b, got %0d last %0b",
                                 want.code, want.last, character_o, last_o));
      end
    end
  end

endmodule

// File: files.f
rtl/i2da_pkg.sv
rtl/i2da_cell.sv
rtl/int_to_decimal_ascii_core.sv
tb/tb_top.sv
